[sv/assert_macros.svh]
// assertion macros used by the session table controller
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define CHK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// next cycle implication
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

[sv/pss_pkg.sv]
// package for the proportional share session table
// constants, types and codes used by every module
package pss_pkg;
  localparam int MaxSessions = 16;
  localparam int IdxW = $clog2(MaxSessions);
  localparam int CntW = $clog2(MaxSessions + 1);
  localparam int RateW = 24;
  localparam int IdW = 16;
  localparam int MinW = 16;
  localparam int SumW = RateW + CntW;
  localparam int ProdW = 2 * RateW;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic [0:0] opcode;
    logic [RateW-1:0] requested_rate;
    logic [MinW-1:0] session_minutes;
  } in_word_t;

  typedef struct packed {
    logic [1:0] report_kind;
    logic admitted;
    logic [IdW-1:0] session_id;
    logic [RateW-1:0] granted_rate;
    logic [MinW-1:0] minutes_remaining;
    logic last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;     // capture input word
    logic append;      // write new entry at count
    logic compact;     // copy/skip entry rd_idx during tick
    logic sum_clr;
    logic sum_acc;     // add request of rd_idx
    logic div_start;   // start divide for rd_idx
    logic grant_wr;    // write grant of rd_idx
    logic count_set;   // count <= wr_idx
    logic [IdxW-1:0] rd_idx;
    logic [CntW-1:0] wr_idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CntW-1:0] count;
    logic div_done;
    logic alive;       // entry rd_idx survives tick
    logic [0:0] opcode;
  } status_t;
endpackage

[sv/pss_if.sv]
// valid/ready channel carrying one word
// uses no other file
interface pss_if #(parameter type word_t = logic) (input logic clk);
  logic valid;
  logic ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/pss_div.sv]
// restoring divider, one quotient bit per cycle
// uses pss_pkg
module pss_div (
  input logic clk,
  input logic rst,
  input logic start,
  input logic [pss_pkg::ProdW-1:0] dividend,
  input logic [pss_pkg::SumW-1:0] divisor,
  output logic done,
  output logic [pss_pkg::RateW-1:0] quotient
);
  import pss_pkg::*;
  localparam int StepW = $clog2(ProdW + 1);
  logic [ProdW-1:0] q;
  logic [SumW:0] rem;
  logic [SumW-1:0] dsr;
  logic [StepW-1:0] step;
  logic busy;
  logic [SumW:0] trial;

  always_comb begin
    trial = {rem[SumW-1:0], q[ProdW-1]} - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= StepW'(ProdW);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[SumW]) begin
        rem <= trial;
        q <= {q[ProdW-2:0], 1'b1};
      end else begin
        rem <= {rem[SumW-1:0], q[ProdW-1]};
        q <= {q[ProdW-2:0], 1'b0};
      end
    end
  end

  assign quotient = q[RateW-1:0];
endmodule

[sv/pss_datapath.sv]
// session table storage, request sum, multiplier and divider
// uses pss_pkg, pss_div
module pss_datapath (
  input logic clk,
  input logic rst,
  input pss_pkg::cmd_t cmd,
  input pss_pkg::in_word_t in_word,
  input logic [pss_pkg::RateW-1:0] capacity,
  output pss_pkg::status_t status,
  output logic [pss_pkg::IdW-1:0] rd_id,
  output logic [pss_pkg::RateW-1:0] rd_grant,
  output logic [pss_pkg::MinW-1:0] rd_minutes,
  output logic grant_full,
  output logic [pss_pkg::IdW-1:0] next_id
);
  import pss_pkg::*;
  logic [IdW-1:0] ids [MaxSessions];
  logic [RateW-1:0] reqs [MaxSessions];
  logic [RateW-1:0] grants [MaxSessions];
  logic [MinW-1:0] mins [MaxSessions];
  logic [CntW-1:0] count;
  logic [SumW-1:0] sum;
  in_word_t held;
  logic [ProdW-1:0] prod;
  logic div_done;
  logic [RateW-1:0] quot;
  logic [IdxW-1:0] wi;

  assign wi = cmd.wr_idx[IdxW-1:0];
  assign grant_full = sum <= SumW'(capacity);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      next_id <= IdW'(1);
    end else begin
      if (cmd.append) begin
        count <= count + 1'b1;
        next_id <= next_id + 1'b1;
      end else if (cmd.count_set) begin
        count <= cmd.wr_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) held <= in_word;
    if (cmd.sum_clr) sum <= '0;
    else if (cmd.sum_acc) sum <= sum + SumW'(reqs[cmd.rd_idx]);
    if (cmd.div_start) prod <= reqs[cmd.rd_idx] * capacity;
    if (cmd.append) begin
      ids[count[IdxW-1:0]] <= next_id;
      reqs[count[IdxW-1:0]] <= held.requested_rate;
      mins[count[IdxW-1:0]] <= held.session_minutes;
    end
    if (cmd.compact) begin
      ids[wi] <= ids[cmd.rd_idx];
      reqs[wi] <= reqs[cmd.rd_idx];
      mins[wi] <= mins[cmd.rd_idx] - 1'b1;
    end
    if (cmd.grant_wr)
      grants[cmd.rd_idx] <= grant_full ? reqs[cmd.rd_idx] : quot;
  end

  // divider starts the cycle after the product is registered
  logic div_go;
  always_ff @(posedge clk) begin
    if (rst) div_go <= 1'b0;
    else div_go <= cmd.div_start;
  end

  pss_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .dividend(prod), .divisor(sum),
    .done(div_done), .quotient(quot)
  );

  assign rd_id = ids[cmd.rd_idx];
  assign rd_grant = grants[cmd.rd_idx];
  assign rd_minutes = mins[cmd.rd_idx];
  assign status.count = count;
  assign status.div_done = div_done;
  assign status.alive = mins[cmd.rd_idx] > MinW'(1);
  assign status.opcode = held.opcode;
endmodule

[sv/pss_ctrl.sv]
// sequencer for add, tick, reallocation and reporting
// uses pss_pkg, assert_macros.svh
module pss_ctrl (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input logic out_ready,
  output pss_pkg::out_word_t out_word,
  input logic [4:0] limit,
  input pss_pkg::status_t status,
  input logic [pss_pkg::IdW-1:0] rd_id,
  input logic [pss_pkg::RateW-1:0] rd_grant,
  input logic [pss_pkg::MinW-1:0] rd_minutes,
  input logic grant_full,
  input logic [pss_pkg::IdW-1:0] next_id,
  output pss_pkg::cmd_t cmd
);
  import pss_pkg::*;
  `include "assert_macros.svh"
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_COMPACT = 4'd2;
  localparam logic [3:0] S_SUM = 4'd3;
  localparam logic [3:0] S_GRANT = 4'd4;
  localparam logic [3:0] S_DIV = 4'd5;
  localparam logic [3:0] S_REPLY = 4'd6;
  localparam logic [3:0] S_REPORT = 4'd7;
  localparam logic [3:0] S_WAIT = 4'd8;
  localparam logic [3:0] S_PDIV = 4'd9;

  logic [3:0] state, state_next;
  logic [CntW-1:0] idx, idx_next, wr, wr_next;
  logic [IdW-1:0] new_id;
  logic [CntW-1:0] lim;
  out_word_t word_next;
  logic load_out;

  assign lim = (limit > 5'(MaxSessions)) ? CntW'(MaxSessions) : CntW'(limit);
  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd = '0;
    cmd.rd_idx = idx[IdxW-1:0];
    cmd.wr_idx = wr;
    state_next = state;
    idx_next = idx;
    wr_next = wr;
    load_out = 1'b0;
    word_next = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        idx_next = '0;
        wr_next = '0;
        if (status.opcode == OP_TICK) begin
          state_next = S_COMPACT;
        end else if (status.count >= lim) begin
          load_out = 1'b1;
          word_next.report_kind = KIND_ADD;
          word_next.last = 1'b1;
          state_next = S_WAIT;
        end else begin
          cmd.append = 1'b1;
          wr_next = status.count;
          cmd.sum_clr = 1'b1;
          state_next = S_SUM;
        end
      end
      S_COMPACT: begin
        if (idx == status.count) begin
          cmd.count_set = 1'b1;
          cmd.sum_clr = 1'b1;
          idx_next = '0;
          state_next = S_SUM;
        end else begin
          if (status.alive) begin
            cmd.compact = 1'b1;
            wr_next = wr + 1'b1;
          end
          idx_next = idx + 1'b1;
        end
      end
      S_SUM: begin
        if (idx == status.count) begin
          idx_next = '0;
          state_next = S_GRANT;
        end else begin
          cmd.sum_acc = 1'b1;
          idx_next = idx + 1'b1;
        end
      end
      S_GRANT: begin
        if (idx == status.count) begin
          idx_next = '0;
          state_next = (status.opcode == OP_ADD) ? S_REPLY : S_REPORT;
        end else if (grant_full) begin
          cmd.grant_wr = 1'b1;
          idx_next = idx + 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_PDIV;
        end
      end
      S_PDIV: state_next = S_DIV;
      S_DIV: begin
        if (status.div_done) begin
          cmd.grant_wr = 1'b1;
          idx_next = idx + 1'b1;
          state_next = S_GRANT;
        end
      end
      S_REPLY: begin
        cmd.rd_idx = wr[IdxW-1:0];
        load_out = 1'b1;
        word_next.report_kind = KIND_ADD;
        word_next.admitted = 1'b1;
        word_next.session_id = new_id;
        word_next.granted_rate = rd_grant;
        word_next.minutes_remaining = rd_minutes;
        word_next.last = 1'b1;
        state_next = S_WAIT;
      end
      S_REPORT: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          if (status.count == '0) begin
            word_next.report_kind = KIND_EMPTY;
            word_next.last = 1'b1;
            state_next = S_WAIT;
          end else begin
            word_next.report_kind = KIND_REPORT;
            word_next.session_id = rd_id;
            word_next.granted_rate = rd_grant;
            word_next.minutes_remaining = rd_minutes;
            word_next.last = (idx + 1'b1) == status.count;
            idx_next = idx + 1'b1;
            if (word_next.last) state_next = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      idx <= '0;
      wr <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      wr <= wr_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_word <= word_next;
    if (cmd.append) new_id <= next_id;
  end

  `CHK_IMPL(a_load_free, load_out, !out_valid || out_ready)
  `CHK_IMPL(a_idle_no_out_load, state == S_IDLE, !load_out)
  `CHK_NEXT(a_accept_decide, in_valid && in_ready, state == S_DECIDE)
endmodule

[sv/proportional_share_session_table.sv]
// top level of the proportional share session table
// uses pss_pkg, pss_if, pss_ctrl, pss_datapath
//
//  channel  dir  word         notes
//  in       in   in_word_t    add or tick
//  out      out  out_word_t   replies and reports, last marks end
//  cfg      in   index, data  0 capacity, 1 limit
//
// an add appends its entry, sums the requests of all n entries, writes the n grants and then replies
// with scaling each of the n grants is computed in the shared serial divider
// a tick first compacts the old entries, then reallocates and sends a report word per surviving entry
// reset clears count, sets next id to 1 and loads capacity 25600 and limit 10; the table is undefined until written
// input is held off while an item is in progress; output stalls hold the word
module proportional_share_session_table (
  input logic clk,
  input logic rst,
  pss_if.sink in_ch,
  pss_if.source out_ch,
  input logic cfg_we,
  input logic [0:0] cfg_index,
  input logic [23:0] cfg_data
);
  import pss_pkg::*;
  logic [RateW-1:0] capacity;
  logic [4:0] limit;
  cmd_t cmd;
  status_t status;
  logic [IdW-1:0] rd_id, next_id;
  logic [RateW-1:0] rd_grant;
  logic [MinW-1:0] rd_minutes;
  logic grant_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= RateW'(25600);
      limit <= 5'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPACITY: capacity <= cfg_data;
        REG_LIMIT: limit <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  pss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_word(out_ch.data),
    .limit(limit), .status(status), .rd_id(rd_id), .rd_grant(rd_grant),
    .rd_minutes(rd_minutes), .grant_full(grant_full), .next_id(next_id),
    .cmd(cmd)
  );

  pss_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_word(in_ch.data), .capacity(capacity),
    .status(status), .rd_id(rd_id), .rd_grant(rd_grant), .rd_minutes(rd_minutes),
    .grant_full(grant_full), .next_id(next_id)
  );
endmodule

[verif/pss_tb_if.sv]
`timescale 1ns / 100ps
// valid/ready channel instances used by the testbench are taken from pss_if
// this file holds the testbench side helper types; depends on pss_pkg
package pss_tb_pkg;
  import pss_pkg::*;
  typedef struct {
    in_word_t w;
    logic chk;
    out_word_t exp_w;
  } stim_row_t;
endpackage

[verif/tb.sv]
`timescale 1ns / 100ps
// testbench for proportional_share_session_table: directed table then random adds and ticks,
// every reply and session report checked against a behavioural session table model
// depends on pss_pkg, pss_if, pss_tb_pkg and the block rtl
module tb;
  import pss_pkg::*;
  import pss_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_CAPACITY;
  logic [23:0] cfg_data = '0;

  pss_if #(.word_t(in_word_t)) in_ch (clk);
  pss_if #(.word_t(out_word_t)) out_ch (clk);

  proportional_share_session_table u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // session table model
  logic [15:0] tbl_id [MaxSessions];
  logic [23:0] tbl_req [MaxSessions];
  logic [23:0] tbl_grant [MaxSessions];
  logic [15:0] tbl_min [MaxSessions];
  int tbl_count;
  logic [15:0] id_next;
  logic [23:0] capacity;
  logic [4:0] limit;

  out_word_t reply_q[$];
  int errors = 0;
  int idle_pct = 27;
  bit hold_off = 0;
  int quiet_cycles = 0;

  function automatic out_word_t mk(logic [1:0] k, logic a, logic [15:0] id,
                                   logic [23:0] r, logic [15:0] m, logic l);
    out_word_t o;
    o.report_kind = k; o.admitted = a; o.session_id = id;
    o.granted_rate = r; o.minutes_remaining = m; o.last = l;
    return o;
  endfunction

  function automatic void share_out();
    logic [63:0] total;
    logic [63:0] g;
    total = 0;
    for (int i = 0; i < tbl_count; i++) total += tbl_req[i];
    for (int i = 0; i < tbl_count; i++) begin
      if (total <= capacity) tbl_grant[i] = tbl_req[i];
      else begin
        g = (64'(tbl_req[i]) * capacity) / total;
        tbl_grant[i] = g[23:0];
      end
    end
  endfunction

  function automatic void predict_session_words(in_word_t w);
    int lim, n;
    lim = (limit > MaxSessions) ? MaxSessions : limit;
    if (w.opcode == OP_ADD) begin
      if (tbl_count >= lim) begin
        reply_q.push_back(mk(KIND_ADD, 0, 0, 0, 0, 1));
        return;
      end
      n = tbl_count;
      tbl_id[n] = id_next; tbl_req[n] = w.requested_rate;
      tbl_grant[n] = 0; tbl_min[n] = w.session_minutes;
      tbl_count++;
      id_next++;
      share_out();
      reply_q.push_back(mk(KIND_ADD, 1, tbl_id[n], tbl_grant[n], tbl_min[n], 1));
      return;
    end
    n = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_min[i] > 1) begin
        tbl_id[n] = tbl_id[i]; tbl_req[n] = tbl_req[i];
        tbl_grant[n] = tbl_grant[i]; tbl_min[n] = tbl_min[i] - 1;
        n++;
      end
    end
    tbl_count = n;
    share_out();
    if (n == 0) reply_q.push_back(mk(KIND_EMPTY, 0, 0, 0, 0, 1));
    for (int i = 0; i < n; i++)
      reply_q.push_back(mk(KIND_REPORT, 0, tbl_id[i], tbl_grant[i], tbl_min[i],
                           i == n - 1));
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [23:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAPACITY) capacity = val; else limit = val[4:0];
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  // compares the model's last predicted word of the item with the typed value where chk is set
  task automatic send_word(in_word_t w, logic chk, out_word_t exp_w);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    predict_session_words(w);
    if (chk && reply_q[$] !== exp_w) begin
      $display("%0t directed row: typed %h model %h", $time, exp_w, reply_q[$]);
      errors++;
    end
  endtask

  function automatic in_word_t iw(logic op, logic [23:0] r, logic [15:0] m);
    in_word_t w;
    w.opcode = op; w.requested_rate = r; w.session_minutes = m;
    return w;
  endfunction

  function automatic in_word_t rand_word(int tick_pct);
    logic [23:0] r;
    case ($urandom_range(3))
      0: r = $urandom_range(24'hFFFFFF);
      1: r = $urandom_range(12800);
      default: r = $urandom_range(3000);
    endcase
    return iw($urandom_range(99) < tick_pct, r,
              ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6)));
  endfunction

  // receiver
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_off && !(idle_pct != 0 && $urandom_range(99) < idle_pct);
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (reply_q.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, out_ch.data);
        errors++;
      end else begin
        out_word_t e;
        e = reply_q.pop_front();
        if (out_ch.data.report_kind !== e.report_kind ||
            out_ch.data.admitted !== e.admitted ||
            out_ch.data.session_id !== e.session_id ||
            out_ch.data.granted_rate !== e.granted_rate ||
            out_ch.data.minutes_remaining !== e.minutes_remaining ||
            out_ch.data.last !== e.last) begin
          $display("%0t mismatch: expected %h actual %h", $time, e, out_ch.data);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 200000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  stim_row_t rows[$];

  initial begin
    in_word_t w;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    tbl_count = 0; id_next = 1; capacity = 25600; limit = 10;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{iw(OP_TICK, 0, 0), 1, mk(KIND_EMPTY, 0, 0, 0, 0, 1)});
    rows.push_back('{iw(OP_ADD, 24'hFFFFFF, 16'hFFFF), 1,
                     mk(KIND_ADD, 1, 1, 25600, 16'hFFFF, 1)});
    rows.push_back('{iw(OP_ADD, 0, 0), 0, '0});
    rows.push_back('{iw(OP_ADD, 24'h000100, 2), 0, '0});
    rows.push_back('{iw(OP_TICK, 24'hFFFFFF, 16'hFFFF), 0, '0});
    rows.push_back('{iw(OP_TICK, 0, 0), 0, '0});
    foreach (rows[i]) send_word(rows[i].w, rows[i].chk, rows[i].exp_w);
    drain();

    write_reg(REG_LIMIT, 0);
    send_word(iw(OP_ADD, 100, 5), 1, mk(KIND_ADD, 0, 0, 0, 0, 1));
    drain();
    write_reg(REG_LIMIT, 31);
    write_reg(REG_CAPACITY, 0);
    for (int i = 0; i < 18; i++) send_word(iw(OP_ADD, 24'h000001 << (i % 24), 3), 0, '0);
    drain();
    send_word(iw(OP_TICK, 0, 0), 0, '0);
    drain();
    write_reg(REG_CAPACITY, 24'hFFFFFF);
    send_word(iw(OP_ADD, 24'hABCDEF, 1), 0, '0);
    send_word(iw(OP_TICK, 0, 0), 0, '0);
    send_word(iw(OP_TICK, 0, 0), 0, '0);
    send_word(iw(OP_TICK, 0, 0), 0, '0);
    drain();

    // long output hold-off while input keeps coming
    fork
      begin hold_off = 1; repeat (3000) @(posedge clk); hold_off = 0; end
      for (int i = 0; i < 20; i++) send_word(rand_word(20), 0, '0);
    join
    drain();

    // small limit first so refusals are frequent, then random limits and capacities
    write_reg(REG_LIMIT, 1);
    write_reg(REG_CAPACITY, 25600);
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) idle_pct = 0;
      else idle_pct = 27;
      for (int i = 0; i < 45; i++) send_word(rand_word(ph == 0 ? 40 : 20), 0, '0);
      drain();
      write_reg(REG_LIMIT, 24'($urandom_range(2, 16)));
      write_reg(REG_CAPACITY, 24'($urandom_range(100, 60000)));
    end

    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
